// File: rtl/lateral_corridor_bounds_defines.svh
// assertion macros shared by the lateral corridor bounds checks
`ifndef LATERAL_CORRIDOR_BOUNDS_DEFINES_SVH
`define LATERAL_CORRIDOR_BOUNDS_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LCB_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcb check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define LCB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcb check failed");

`endif

// File: rtl/lcb_pkg.sv
// types, codes and saturation helper for the lateral corridor bounds block
package lcb_pkg;

	localparam int Q_W = 24;
	localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		FN_CLEAR    = 2'd0,
		FN_APPEND   = 2'd1,
		FN_OBSTACLE = 2'd2,
		FN_READ     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_LOADED = 2'd2,
		ST_SKIPPED    = 2'd3
	} status_t;

	// configuration register indexes
	localparam logic [1:0] CFG_LANE_WIDTH      = 2'd0;
	localparam logic [1:0] CFG_SAFETY_MARGIN   = 2'd1;
	localparam logic [1:0] CFG_OBSTACLE_LENGTH = 2'd2;
	localparam logic [1:0] CFG_OBSTACLE_WIDTH  = 2'd3;

	typedef struct packed {
		status_t                 status;
		logic signed [Q_W-1:0]   lower;
		logic signed [Q_W-1:0]   upper;
		logic                    left;
	} result_t;

	// clamp a 25-bit sum to the signed 24-bit range
	function automatic logic signed [Q_W-1:0] sat24(input logic signed [Q_W:0] v);
		logic signed [Q_W-1:0] r;
		if (v[Q_W] != v[Q_W-1]) begin
			r = v[Q_W] ? Q_MIN : Q_MAX;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/lateral_corridor_bounds.sv
// lateral corridor bounds: path table, obstacle window search and bound update
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  cfg     | cfg_wen cfg_index cfg_data                | write when cfg_wen
//  in      | func station offset entry_index           | in_valid & in_ready
//  out     | status lower_bound upper_bound passed_left| out_valid & out_ready
//
// clear and append go straight to S_DONE, while a read first fetches its entry
// in S_RD; from S_DONE the result enters the output register once that is free
// an obstacle runs three nearest-index walks over the point ram (one station
// per cycle), then a read-modify-write sweep of the bounds ram over the window,
// then reads back the bounds at the center index for its result
// one item in flight: in_ready only in idle, a result waits in the output register
// reset returns the config registers to their defaults and empties the table;
// the table rams are not cleared and hold garbage until written
module lateral_corridor_bounds #(
	parameter int PATH_POINTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wen,
	input  logic [1:0]             cfg_index,
	input  logic [11:0]            cfg_data,
	// input items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lcb_pkg::func_t         func,
	input  logic signed [23:0]     station,
	input  logic signed [23:0]     offset,
	input  logic [5:0]             entry_index,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output lcb_pkg::status_t       status,
	output logic signed [23:0]     lower_bound,
	output logic signed [23:0]     upper_bound,
	output logic                   passed_left
);

	import lcb_pkg::*;

	localparam int IDX_W = $clog2(PATH_POINTS);
	localparam int CNT_W = $clog2(PATH_POINTS + 1);

	// sequencer states
	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_FIRST  = 14'b00000000000010,  // issue read of first station
		S_CHK0   = 14'b00000000000100,  // below first station
		S_CHKL   = 14'b00000000001000,  // at or past last station
		S_WALK   = 14'b00000000010000,  // one bracket test per cycle
		S_OFF_RD = 14'b00000000100000,
		S_OFF    = 14'b00000001000000,  // side decision from center offset
		S_CLR    = 14'b00000010000000,  // clearance value
		S_UPD_RD = 14'b00000100000000,
		S_UPD    = 14'b00001000000000,  // bound read-modify-write sweep
		S_RES_RD = 14'b00010000000000,
		S_RES    = 14'b00100000000000,
		S_RD     = 14'b01000000000000,  // read item data
		S_DONE   = 14'b10000000000000   // hand result to output register
	} state_t;

	// which nearest-index search the walk is serving
	typedef enum logic [1:0] {
		PH_CENTER = 2'd0,
		PH_LOW    = 2'd1,
		PH_HIGH   = 2'd2
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;

	logic [11:0]            lane_width_q;
	logic [9:0]             safety_margin_q;
	logic [11:0]            obstacle_length_q;
	logic [11:0]            obstacle_width_q;

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       ptr_q;
	logic [IDX_W-1:0]       c_q;
	logic [IDX_W-1:0]       a_q;
	logic [IDX_W-1:0]       b_q;
	logic signed [23:0]     st_q;
	logic signed [23:0]     off_q;
	logic signed [23:0]     key_q;
	logic signed [23:0]     prev_q;
	logic signed [23:0]     v_q;
	logic                   left_q;
	result_t                res_q;
	result_t                out_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   full;
	logic                   read_miss;
	logic                   load_out;
	result_t                res_idle;
	logic [CNT_W-1:0]       cnt_m1;
	logic [IDX_W-1:0]       last_idx;
	logic [IDX_W-1:0]       ptr_inc;

	// road edge bounds straight from config
	logic [12:0]            lw_p1;
	logic [13:0]            lw3;
	logic signed [13:0]     road_lo14;
	logic signed [13:0]     road_hi14;
	logic signed [23:0]     road_lo;
	logic signed [23:0]     road_hi;

	// ram ports
	logic                   pt_we;
	logic [IDX_W-1:0]       pt_raddr;
	logic [47:0]            pt_rdata;
	logic                   bd_we;
	logic [IDX_W-1:0]       bd_waddr;
	logic [47:0]            bd_wdata;
	logic [IDX_W-1:0]       bd_raddr;
	logic [47:0]            bd_rdata;

	logic signed [23:0]     pt_st;
	logic signed [23:0]     pt_off;
	logic signed [23:0]     bd_lo;
	logic signed [23:0]     bd_hi;

	// shared saturating adder
	logic [13:0]            half14;
	logic [11:0]            clr12;
	logic [13:0]            clr14;
	logic signed [23:0]     sa_a;
	logic signed [13:0]     sa_b;
	logic signed [24:0]     sa_sum;
	logic signed [23:0]     sa_out;

	// walk comparator
	logic signed [25:0]     key_x2;
	logic signed [25:0]     pair_sum;
	logic                   take_prev;
	logic                   walk_done;
	logic                   walk_fail;
	logic [IDX_W-1:0]       walk_idx;

	logic                   raise;
	logic                   cut;
	logic [47:0]            upd_wdata;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign full      = (count_q == CNT_W'(PATH_POINTS));
	assign read_miss = ({1'b0, entry_index} >= 7'(count_q));
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign last_idx  = cnt_m1[IDX_W-1:0];
	assign ptr_inc   = ptr_q + 1'b1;

	// lower edge = margin - ceil(lane/2), upper edge = floor(3*lane/2) - margin
	assign lw_p1     = {1'b0, lane_width_q} + 13'd1;
	assign lw3       = {2'b00, lane_width_q} + {1'b0, lane_width_q, 1'b0};
	assign road_lo14 = $signed({4'b0000, safety_margin_q}) - $signed({2'b00, lw_p1[12:1]});
	assign road_hi14 = $signed({1'b0, lw3[13:1]}) - $signed({4'b0000, safety_margin_q});
	assign road_lo   = {{10{road_lo14[13]}}, road_lo14};
	assign road_hi   = {{10{road_hi14[13]}}, road_hi14};

	assign pt_st  = pt_rdata[47:24];
	assign pt_off = pt_rdata[23:0];
	assign bd_lo  = bd_rdata[47:24];
	assign bd_hi  = bd_rdata[23:0];

	// result of items that finish without a table walk
	always_comb begin
		res_idle = '0;
		case (func)
			FN_APPEND: begin
				if (full) begin
					res_idle.status = ST_FULL;
				end else begin
					res_idle.lower = road_lo;
					res_idle.upper = road_hi;
				end
			end
			FN_OBSTACLE: begin
				if (count_q == '0) begin
					res_idle.status = ST_SKIPPED;
				end
			end
			FN_READ: begin
				if (read_miss) begin
					res_idle.status = ST_NOT_LOADED;
				end
			end
			default: begin
				res_idle.status = ST_DONE;
			end
		endcase
	end

	// half length for the window, half width plus margin for the clearance
	assign half14 = {3'b000, obstacle_length_q[11:1]};
	assign clr12  = {1'b0, obstacle_width_q[11:1]} + {2'b00, safety_margin_q};
	assign clr14  = {2'b00, clr12};

	always_comb begin
		sa_a = st_q;
		sa_b = $signed(half14);
		case (state_q)
			S_OFF: begin
				sa_b = -$signed(half14);
			end
			S_CLR: begin
				sa_a = off_q;
				sa_b = left_q ? $signed(clr14) : -$signed(clr14);
			end
			default: begin
				sa_b = $signed(half14);
			end
		endcase
	end

	assign sa_sum = {sa_a[23], sa_a} + {{11{sa_b[13]}}, sa_b};
	assign sa_out = sat24(sa_sum);

	// tie goes to the later index: pick the earlier one only if 2s < prev + cur
	assign key_x2    = {key_q[23], key_q, 1'b0};
	assign pair_sum  = {{2{prev_q[23]}}, prev_q} + {{2{pt_st[23]}}, pt_st};
	assign take_prev = (key_x2 < pair_sum);

	always_comb begin
		walk_done = 1'b0;
		walk_fail = 1'b0;
		walk_idx  = ptr_q;
		case (state_q)
			S_CHK0: begin
				if (key_q < pt_st) begin
					walk_done = 1'b1;
					walk_idx  = '0;
				end
			end
			S_CHKL: begin
				if (key_q >= pt_st) begin
					walk_done = 1'b1;
					walk_idx  = last_idx;
				end
			end
			S_WALK: begin
				if (key_q >= prev_q && key_q < pt_st) begin
					walk_done = 1'b1;
					walk_idx  = take_prev ? ptr_q - 1'b1 : ptr_q;
				end else if (ptr_q == last_idx) begin
					// unsorted table, no bracket found
					walk_fail = 1'b1;
				end
			end
			default: begin
				walk_done = 1'b0;
			end
		endcase
	end

	// point ram read address follows the walk one entry ahead
	always_comb begin
		case (state_q)
			S_CHK0:   pt_raddr = last_idx;
			S_CHKL:   pt_raddr = IDX_W'(1);
			S_WALK:   pt_raddr = ptr_inc;
			S_OFF_RD: pt_raddr = c_q;
			default:  pt_raddr = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:   bd_raddr = entry_index[IDX_W-1:0];
			S_UPD:    bd_raddr = ptr_inc;
			S_RES_RD: bd_raddr = c_q;
			default:  bd_raddr = ptr_q;
		endcase
	end

	// pass left raises the lower bound, pass right lowers the upper bound
	assign raise     = (v_q > bd_lo);
	assign cut       = (v_q < bd_hi);
	assign upd_wdata = left_q ? {(raise ? v_q : bd_lo), bd_hi}
	                          : {bd_lo, (cut ? v_q : bd_hi)};

	assign pt_we    = accept && (func == FN_APPEND) && !full;
	assign bd_we    = pt_we || (state_q == S_UPD);
	assign bd_waddr = (state_q == S_IDLE) ? count_q[IDX_W-1:0] : ptr_q;
	assign bd_wdata = (state_q == S_IDLE) ? {road_lo, road_hi} : upd_wdata;

	lcb_ram #(
		.WIDTH (48),
		.DEPTH (PATH_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({station, offset}),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	lcb_ram #(
		.WIDTH (48),
		.DEPTH (PATH_POINTS)
	) u_bound_ram (
		.clk   (clk),
		.we    (bd_we),
		.waddr (bd_waddr),
		.wdata (bd_wdata),
		.raddr (bd_raddr),
		.rdata (bd_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_width_q      <= 12'd896;
			safety_margin_q   <= 10'd128;
			obstacle_length_q <= 12'd1280;
			obstacle_width_q  <= 12'd512;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_LANE_WIDTH:      lane_width_q      <= cfg_data;
				CFG_SAFETY_MARGIN:   safety_margin_q   <= cfg_data[9:0];
				CFG_OBSTACLE_LENGTH: obstacle_length_q <= cfg_data;
				CFG_OBSTACLE_WIDTH:  obstacle_width_q  <= cfg_data;
				default:             lane_width_q      <= lane_width_q;
			endcase
		end
	end

	// output valid: set when a result is loaded, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_CENTER;
			count_q     <= '0;
			ptr_q       <= '0;
			c_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			st_q        <= '0;
			off_q       <= '0;
			key_q       <= '0;
			prev_q      <= '0;
			v_q         <= '0;
			left_q      <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q    <= station;
						off_q   <= offset;
						key_q   <= station;
						left_q  <= 1'b0;
						phase_q <= PH_CENTER;
						res_q   <= res_idle;
						case (func)
							FN_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							FN_APPEND: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_DONE;
							end
							FN_OBSTACLE: begin
								if (count_q == '0) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_FIRST;
								end
							end
							FN_READ: begin
								if (read_miss) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_FIRST: begin
					state_q <= S_CHK0;
				end
				S_CHK0: begin
					prev_q <= pt_st;
					if (!walk_done) begin
						state_q <= S_CHKL;
					end
				end
				S_CHKL: begin
					ptr_q <= IDX_W'(1);
					if (!walk_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					prev_q <= pt_st;
					ptr_q  <= ptr_inc;
				end
				S_OFF_RD: begin
					state_q <= S_OFF;
				end
				S_OFF: begin
					left_q  <= (pt_off > off_q);
					key_q   <= sa_out;
					phase_q <= PH_LOW;
					state_q <= S_FIRST;
				end
				S_CLR: begin
					v_q   <= sa_out;
					ptr_q <= a_q;
					// empty window: nothing to update
					state_q <= (a_q > b_q) ? S_RES_RD : S_UPD_RD;
				end
				S_UPD_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (ptr_q == b_q) begin
						state_q <= S_RES_RD;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				S_RES_RD: begin
					state_q <= S_RES;
				end
				S_RES: begin
					res_q   <= '{status: ST_DONE, lower: bd_lo, upper: bd_hi, left: left_q};
					state_q <= S_DONE;
				end
				S_RD: begin
					res_q   <= '{status: ST_DONE, lower: bd_lo, upper: bd_hi, left: 1'b0};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// end of a nearest-index walk
			if (walk_done) begin
				case (phase_q)
					PH_CENTER: begin
						c_q     <= walk_idx;
						state_q <= S_OFF_RD;
					end
					PH_LOW: begin
						a_q     <= walk_idx;
						key_q   <= sa_out;
						phase_q <= PH_HIGH;
						state_q <= S_FIRST;
					end
					PH_HIGH: begin
						b_q     <= walk_idx;
						state_q <= S_CLR;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end else if (walk_fail) begin
				// skipped obstacle keeps the side once the center is known
				res_q   <= '{status: ST_SKIPPED, lower: '0, upper: '0, left: left_q};
				state_q <= S_DONE;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign lower_bound = out_q.lower;
	assign upper_bound = out_q.upper;
	assign passed_left = out_q.left;

endmodule

// File: rtl/lcb_ram.sv
// generic single-write, single-read ram with registered read data
module lcb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lcb_checker.sv
// port-level checks for the lateral corridor bounds block, bound to the top level
`include "lateral_corridor_bounds_defines.svh"

module lcb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input lcb_pkg::status_t   status,
	input logic signed [23:0] lower_bound,
	input logic signed [23:0] upper_bound,
	input logic               passed_left
);

	import lcb_pkg::*;

	// a waiting result holds its fields
	`LCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(lower_bound) && $stable(upper_bound) && $stable(passed_left))

	// one item at a time: busy right after an accept
	`LCB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// full table and unloaded index give zero fields
	`LCB_ASSERT_NOW(a_full_zero, out_valid && (status == ST_FULL || status == ST_NOT_LOADED), lower_bound == 24'sd0 && upper_bound == 24'sd0 && !passed_left)

	// skipped obstacle gives zero bounds
	`LCB_ASSERT_NOW(a_skip_zero, out_valid && status == ST_SKIPPED, lower_bound == 24'sd0 && upper_bound == 24'sd0)

endmodule

bind lateral_corridor_bounds lcb_checker u_lcb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.lower_bound (lower_bound),
	.upper_bound (upper_bound),
	.passed_left (passed_left)
);
